### rtl/ptd_pkg.sv
// Package for the trial-division primality tester: widths and sequencer states.
package ptd_pkg;

  localparam int NUMBER_WIDTH = 32;
  // Trial divisors never pass 2^(NUMBER_WIDTH/2) + 1.
  localparam int DIV_W = NUMBER_WIDTH / 2 + 1;
  // Running square of the divisor, one bit above the number.
  localparam int SQ_W = NUMBER_WIDTH + 1;
  localparam int CNT_W = $clog2(NUMBER_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } ptd_state_t;

endpackage

### rtl/prime_trial_division.sv
// Primality test by trial division using a single bit-serial remainder unit.
//
// Usage: present a number on in_number and raise start while busy is low; the
// transaction is taken at that clock edge. Exactly one result follows: out_valid
// is high for one cycle with out_is_prime, and the receiver cannot stall it.
// A new start is taken in the same cycle that out_valid is shown.
// Zero, one, two, three and even numbers answer in the cycle after the
// transaction. Odd numbers of five and above try the odd divisors from 3 up
// while the divisor square stays within the number. Each divisor costs a
// bound check in ST_CHECK and then a pass through the restoring remainder
// unit in ST_DIV, one quotient bit per cycle. Composite odd numbers stop at
// their smallest factor.
// For odd numbers of five and above, busy is high while the test runs and low
// again when out_valid is shown; numbers settled without the divider never
// raise it. Reset (rst_n low, synchronous) returns the sequencer to idle and
// drops any test in progress without producing its result.
module prime_trial_division
  import ptd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  output logic                    out_valid,
  output logic                    out_is_prime
);

  ptd_state_t state_r, state_nxt;

  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [DIV_W-1:0]        d_r, d_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic [DIV_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_is_prime_r, out_is_prime_nxt;

  logic                    accept;
  logic                    small_num;
  logic                    bound_over;
  logic [DIV_W:0]          rem_sh;
  logic                    rem_ge;
  logic [DIV_W-1:0]        rem_step;
  logic                    div_last;

  assign busy         = (state_r != ST_IDLE);
  assign accept       = start && !busy;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // Numbers below five or even are settled without the divider.
  assign small_num  = (in_number < NUMBER_WIDTH'(5)) || !in_number[0];
  assign bound_over = (sq_r > {1'b0, n_r});

  // One restoring step: bring in the next number bit, subtract if it fits.
  assign rem_sh   = {rem_r, n_r[cnt_r]};
  assign rem_ge   = (rem_sh >= {1'b0, d_r});
  assign rem_step = rem_ge ? DIV_W'(rem_sh - {1'b0, d_r}) : DIV_W'(rem_sh);
  assign div_last = (cnt_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !small_num) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = bound_over ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_nxt = (rem_step == '0) ? ST_IDLE : ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    n_nxt            = n_r;
    d_nxt            = d_r;
    sq_nxt           = sq_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = 1'b0;
    out_is_prime_nxt = out_is_prime_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt  = in_number;
          d_nxt  = DIV_W'(3);
          sq_nxt = SQ_W'(9);
          if (small_num) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = (in_number == NUMBER_WIDTH'(2)) ||
                               (in_number == NUMBER_WIDTH'(3));
          end
        end
      end
      ST_CHECK: begin
        rem_nxt = '0;
        cnt_nxt = CNT_W'(NUMBER_WIDTH - 1);
        if (bound_over) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b1;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (div_last) begin
          if (rem_step == '0) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = 1'b0;
          end else begin
            // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
            d_nxt  = d_r + DIV_W'(2);
            sq_nxt = sq_r + SQ_W'({d_r, 2'b00}) + SQ_W'(4);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    d_r            <= d_nxt;
    sq_r           <= sq_nxt;
    rem_r          <= rem_nxt;
    cnt_r          <= cnt_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

`ifndef ASSERT_OFF
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a test is still running");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < d_r))
    else $error("partial remainder not below divisor");

  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (d_r[0] && (d_r >= DIV_W'(3))))
    else $error("trial divisor not odd or below three");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(accept) || $past(state_r == ST_CHECK) ||
                          $past(state_r == ST_DIV)))
    else $error("result without a transaction in progress");
`endif

endmodule

### bench/tb_prime_trial_division.sv
// Testbench for prime_trial_division: directed and random numbers against a predictor.
`timescale 1ns / 1ps

module tb_prime_trial_division;
  import ptd_pkg::*;

  typedef logic [NUMBER_WIDTH-1:0] number_t;

  typedef struct {
    number_t number;
    bit      is_prime;
  } verdict_t;

  class primality_board;
    verdict_t verdicts_due[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    // Trial division on 3, 5, 7, ... while d*d <= n; trials counts the divisors tried.
    function bit test_prime(input number_t num, output int unsigned trials);
      longint unsigned n;
      longint unsigned d;
      trials = 0;
      n = num;
      if (n < 2) return 1'b0;
      if (n < 4) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
        trials++;
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(input number_t num);
      verdict_t v;
      int unsigned trials;
      v.number = num;
      v.is_prime = test_prime(num, trials);
      verdicts_due.push_back(v);
    endfunction

    function void report(input string msg);
      fails++;
      if (fails <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_verdict(input logic is_prime);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        report($sformatf("unexpected result is_prime=%b", is_prime));
        return;
      end
      v = verdicts_due.pop_front();
      if (is_prime !== v.is_prime)
        report($sformatf("number %0d: expected is_prime=%b, got %b", v.number, v.is_prime,
                         is_prime));
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void leftover();
      while (verdicts_due.size() != 0) begin
        verdict_t v;
        v = verdicts_due.pop_front();
        report($sformatf("number %0d: no result, expected is_prime=%b", v.number, v.is_prime));
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  number_t in_number = '0;
  logic    busy;
  logic    out_valid;
  logic    out_is_prime;

  primality_board sb = new();
  longint unsigned cycle_count = 0;
  longint unsigned cycle_limit = 200000;

  always #10 clk = ~clk;

  prime_trial_division u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_number(in_number);
      if (out_valid) sb.check_verdict(out_is_prime);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Hold start until the transaction is taken; the limit grows with the divisor count.
  task automatic send_number(input number_t num);
    int unsigned trials;
    void'(sb.test_prime(num, trials));
    cycle_limit += 4 * (trials + 2) * (NUMBER_WIDTH + 2) + 64;
    start <= 1'b1;
    in_number <= num;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause_sender(input int unsigned gap);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly small and medium numbers; wide ones only when their smallest factor comes early.
  function automatic number_t draw_number();
    number_t num;
    int unsigned trials;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    do begin
      if (pick < 4) num = number_t'($urandom_range(0, 255));
      else if (pick < 7) num = number_t'($urandom_range(0, 1 << 18));
      else num = number_t'({$urandom, $urandom});
      void'(sb.test_prime(num, trials));
    end while (trials > 300);
    return num;
  endfunction

  initial begin
    number_t directed[$];
    int unsigned sent;
    int unsigned burst;

    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15, 32'd25,
                 32'd49, 32'd97, 32'd121, 32'd169, 32'd65537, 32'd1000003, 32'd16777213,
                 32'h7FFFFFFE, 32'h80000000, 32'h80000001, 32'h55555555, 32'hAAAAAAAB,
                 32'hFFFFFFFE, 32'hFFFFFFFF};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i]);
    drain_results();

    sent = 0;
    while (sent < 76) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        send_number(draw_number());
        sent++;
      end
      case ($urandom_range(0, 7))
        0: drain_results();
        1, 2: ;
        default: pause_sender($urandom_range(1, 6));
      endcase
    end

    drain_results();
    repeat (2 * NUMBER_WIDTH + 8) @(posedge clk);
    sb.leftover();

    if (sb.fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
